// ===== hw/rtl/stabilizer_rowsum_phase_defines.svh =====
// ----------------------------------------------------------------------------
// stabilizer_rowsum_phase_defines.svh
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef STABILIZER_ROWSUM_PHASE_DEFINES_SVH
`define STABILIZER_ROWSUM_PHASE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define SRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define SRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/srp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srp_pkg
// shared constants, phase table and control types for the rowsum phase block
// ----------------------------------------------------------------------------
package srp_pkg;

    localparam int FIELD_BITS    = 64;
    localparam int WORD_BITS_DEF = 64;
    localparam int LANE_BITS     = 8;

    typedef logic [1:0] t_phase;

    // phase of one bit position, indexed by {cx, cz, tx, tz}; 3 stands for -1
    localparam t_phase G_TABLE [0:15] = '{
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd3,
        2'd0, 2'd3, 2'd0, 2'd1, 2'd0, 2'd1, 2'd3, 2'd0
    };

    typedef struct packed {
        logic adv;
        logic last;
    } t_merge_ctl;

endpackage
`default_nettype wire

// ===== hw/rtl/srp_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srp_lane
// classifies one slice of bit positions and registers its phase sum mod 4
// ----------------------------------------------------------------------------
module srp_lane #(
    parameter int LANE_W = srp_pkg::LANE_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_load,
    input  wire logic [LANE_W-1:0] i_cx,
    input  wire logic [LANE_W-1:0] i_cz,
    input  wire logic [LANE_W-1:0] i_tx,
    input  wire logic [LANE_W-1:0] i_tz,
    output srp_pkg::t_phase        o_delta
);
    import srp_pkg::*;

    t_phase r_delta;
    t_phase n_delta;

    always_comb begin
        n_delta = '0;
        for (int b = 0; b < LANE_W; b++) begin
            n_delta = n_delta + G_TABLE[{i_cx[b], i_cz[b], i_tx[b], i_tz[b]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_delta <= n_delta;
        end
    end

    assign o_delta = r_delta;

endmodule
`default_nettype wire

// ===== hw/rtl/srp_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srp_merge
// combines lane phase sums into the mod-4 accumulator, clears it on last beat
// ----------------------------------------------------------------------------
module srp_merge #(
    parameter int NUM_LANES = srp_pkg::WORD_BITS_DEF / srp_pkg::LANE_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire srp_pkg::t_merge_ctl  i_ctl,
    input  wire srp_pkg::t_phase      i_lane_delta [NUM_LANES],
    output srp_pkg::t_phase           o_phase
);
    import srp_pkg::*;

    t_phase r_acc;
    t_phase n_acc;
    t_phase w_sum;

    always_comb begin
        w_sum = r_acc;
        for (int l = 0; l < NUM_LANES; l++) begin
            w_sum = w_sum + i_lane_delta[l];
        end
        n_acc   = i_ctl.last ? '0 : w_sum;
        o_phase = i_ctl.last ? w_sum : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.adv) begin
            r_acc <= n_acc;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/stabilizer_rowsum_phase.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stabilizer_rowsum_phase
// tableau rowsum step: xor update of target words and mod-4 phase per row
// ----------------------------------------------------------------------------
// path: an accepted beat goes through stage one, then the output register
// throughput: one beat per cycle while the output is not stalled; lanes
//   register sums, merge and accumulator update feed the output register
// reset: synchronous, clears both valid stages and the phase accumulator
module stabilizer_rowsum_phase #(
    parameter int WORD_BITS = srp_pkg::WORD_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [srp_pkg::FIELD_BITS-1:0] i_ctrl_x_word,
    input  wire logic [srp_pkg::FIELD_BITS-1:0] i_ctrl_z_word,
    input  wire logic [srp_pkg::FIELD_BITS-1:0] i_targ_x_word,
    input  wire logic [srp_pkg::FIELD_BITS-1:0] i_targ_z_word,
    input  wire logic                           i_last_word,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [srp_pkg::FIELD_BITS-1:0]      o_new_targ_x,
    output logic [srp_pkg::FIELD_BITS-1:0]      o_new_targ_z,
    output logic signed [1:0]                   o_phase_out,
    output logic                                o_phase_valid
);
    import srp_pkg::*;

    localparam int NUM_LANES = (WORD_BITS + LANE_BITS - 1) / LANE_BITS;
    localparam int PAD_BITS  = NUM_LANES * LANE_BITS;
    localparam logic [FIELD_BITS-1:0] WORD_MASK =
        {FIELD_BITS{1'b1}} >> (FIELD_BITS - WORD_BITS);

    logic                  r_s1_valid;
    logic                  r_s1_last;
    logic [FIELD_BITS-1:0] r_s1_x;
    logic [FIELD_BITS-1:0] r_s1_z;
    logic                  r_out_valid;
    logic [FIELD_BITS-1:0] r_out_x;
    logic [FIELD_BITS-1:0] r_out_z;
    t_phase                r_out_phase;
    logic                  r_out_pv;

    logic                  w_out_ready;
    logic                  w_s1_ready;
    logic                  w_take;
    logic                  w_adv;
    logic [PAD_BITS-1:0]   w_cx_pad;
    logic [PAD_BITS-1:0]   w_cz_pad;
    logic [PAD_BITS-1:0]   w_tx_pad;
    logic [PAD_BITS-1:0]   w_tz_pad;
    t_phase                w_lane_delta [NUM_LANES];
    t_phase                w_phase;
    t_merge_ctl            w_ctl;

    assign w_out_ready = !r_out_valid || !i_stall;
    assign w_adv       = r_s1_valid && w_out_ready;
    assign w_s1_ready  = !r_s1_valid || w_out_ready;
    assign w_take      = i_valid && w_s1_ready;
    assign o_stall     = !w_s1_ready;

    // only the low WORD_BITS bits take part; the top lane is zero padded
    assign w_cx_pad = PAD_BITS'(i_ctrl_x_word[WORD_BITS-1:0]);
    assign w_cz_pad = PAD_BITS'(i_ctrl_z_word[WORD_BITS-1:0]);
    assign w_tx_pad = PAD_BITS'(i_targ_x_word[WORD_BITS-1:0]);
    assign w_tz_pad = PAD_BITS'(i_targ_z_word[WORD_BITS-1:0]);

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        srp_lane #(
            .LANE_W (LANE_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_load  (w_take),
            .i_cx    (w_cx_pad[l*LANE_BITS +: LANE_BITS]),
            .i_cz    (w_cz_pad[l*LANE_BITS +: LANE_BITS]),
            .i_tx    (w_tx_pad[l*LANE_BITS +: LANE_BITS]),
            .i_tz    (w_tz_pad[l*LANE_BITS +: LANE_BITS]),
            .o_delta (w_lane_delta[l])
        );
    end

    assign w_ctl.adv  = w_adv;
    assign w_ctl.last = r_s1_last;

    srp_merge #(
        .NUM_LANES (NUM_LANES)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_lane_delta (w_lane_delta),
        .o_phase      (w_phase)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_valid;
        end
        if (w_take) begin
            r_s1_last <= i_last_word;
            r_s1_x    <= (i_ctrl_x_word ^ i_targ_x_word) & WORD_MASK;
            r_s1_z    <= (i_ctrl_z_word ^ i_targ_z_word) & WORD_MASK;
        end
    end

    // output register lets the next beat in while a result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_s1_valid;
        end
        if (w_adv) begin
            r_out_x     <= r_s1_x;
            r_out_z     <= r_s1_z;
            r_out_phase <= w_phase;
            r_out_pv    <= r_s1_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_new_targ_x  = r_out_x;
    assign o_new_targ_z  = r_out_z;
    assign o_phase_out   = signed'(r_out_phase);
    assign o_phase_valid = r_out_pv;

endmodule
`default_nettype wire

// ===== hw/rtl/srp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srp_checker
// port-level checks on the rowsum phase block, bound to the top level
// ----------------------------------------------------------------------------
`include "stabilizer_rowsum_phase_defines.svh"

module srp_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_valid,
    input wire logic                           o_stall,
    input wire logic [srp_pkg::FIELD_BITS-1:0] i_ctrl_x_word,
    input wire logic [srp_pkg::FIELD_BITS-1:0] i_ctrl_z_word,
    input wire logic [srp_pkg::FIELD_BITS-1:0] i_targ_x_word,
    input wire logic [srp_pkg::FIELD_BITS-1:0] i_targ_z_word,
    input wire logic                           i_last_word,
    input wire logic                           o_valid,
    input wire logic                           i_stall,
    input wire logic [srp_pkg::FIELD_BITS-1:0] o_new_targ_x,
    input wire logic [srp_pkg::FIELD_BITS-1:0] o_new_targ_z,
    input wire logic signed [1:0]              o_phase_out,
    input wire logic                           o_phase_valid
);

    logic [4*srp_pkg::FIELD_BITS:0] w_in_beat;

    assign w_in_beat = {i_ctrl_x_word, i_ctrl_z_word, i_targ_x_word, i_targ_z_word, i_last_word};

    // phase is only carried on the last beat of a row
    `SRP_ASSERT_IMP(a_phase_zero, i_clk, i_rst_n, o_valid && !o_phase_valid, o_phase_out == 2'sd0, "phase set on a beat that is not last")

    // input side backs up only when both stages hold beats
    `SRP_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled while output can move")

    // a stalled result beat holds
    `SRP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_new_targ_x) && $stable(o_new_targ_z) && $stable(o_phase_out) && $stable(o_phase_valid), "result changed under stall")

    // a stalled input beat holds
    `SRP_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid && $stable(w_in_beat), "input beat changed under stall")

endmodule

bind stabilizer_rowsum_phase srp_checker u_srp_checker (.*);
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the rowsum phase block: target word xor update and the mod-4 row
// phase, against a bit-level predictor, with random gaps and output stalls
// ----------------------------------------------------------------------------
module tb;

    localparam int WB          = srp_pkg::WORD_BITS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_WORDS = 950;
    localparam logic [63:0] WORD_MASK = (WB >= 64) ? '1 : ((64'd1 << WB) - 64'd1);

    // pauli pair classes, written as {cx, cz, tx, tz}
    localparam logic [3:0] PAIR_NONE   = 4'b0000;
    localparam logic [3:0] PAIR_PLUS_A = 4'b0110;
    localparam logic [3:0] PAIR_MINUS_A = 4'b1001;
    localparam logic [3:0] PAIR_MINUS_C = 4'b1110;

    typedef struct packed {
        logic [63:0] cx;
        logic [63:0] cz;
        logic [63:0] tx;
        logic [63:0] tz;
        logic        last;
    } t_row_word;

    typedef struct packed {
        logic [63:0] nx;
        logic [63:0] nz;
        logic [1:0]  phase;
        logic        phase_valid;
    } t_row_update;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    logic [63:0] i_ctrl_x_word = '0;
    logic [63:0] i_ctrl_z_word = '0;
    logic [63:0] i_targ_x_word = '0;
    logic [63:0] i_targ_z_word = '0;
    logic        i_last_word = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [63:0] o_new_targ_x;
    logic [63:0] o_new_targ_z;
    logic signed [1:0] o_phase_out;
    logic        o_phase_valid;

    t_row_update pending_updates[$];
    t_row_update want;
    logic [1:0]  phase_model = '0;
    logic        steady = 1'b0;
    int          error_count = 0;
    int          cycle_count = 0;
    int          stall_hold = 0;
    int          stall_draw;

    stabilizer_rowsum_phase #(
        .WORD_BITS(WB)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_ctrl_x_word(i_ctrl_x_word),
        .i_ctrl_z_word(i_ctrl_z_word),
        .i_targ_x_word(i_targ_x_word),
        .i_targ_z_word(i_targ_z_word),
        .i_last_word  (i_last_word),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_new_targ_x (o_new_targ_x),
        .o_new_targ_z (o_new_targ_z),
        .o_phase_out  (o_phase_out),
        .o_phase_valid(o_phase_valid)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic int pick_wait();
        if (steady || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // one rowsum step: xor update plus signed count of +1 / -1 positions
    function automatic t_row_update rowsum_step(t_row_word w);
        logic [63:0] cx, cz, tx, tz, plus, minus;
        logic [1:0]  delta;
        t_row_update u;
        cx = w.cx & WORD_MASK;
        cz = w.cz & WORD_MASK;
        tx = w.tx & WORD_MASK;
        tz = w.tz & WORD_MASK;
        plus  = (~cx & cz & tx & ~tz) | (cx & ~cz & tx & tz) | (cx & cz & ~tx & tz);
        minus = (cx & ~cz & ~tx & tz) | (~cx & cz & tx & tz) | (cx & cz & tx & ~tz);
        delta = 2'($countones(plus) - $countones(minus));
        phase_model = phase_model + delta;
        u.nx = tx ^ cx;
        u.nz = tz ^ cz;
        if (w.last) begin
            u.phase = phase_model;
            u.phase_valid = 1'b1;
            phase_model = '0;
        end else begin
            u.phase = '0;
            u.phase_valid = 1'b0;
        end
        return u;
    endfunction

    // count positions spread by a stride of 9 all carry the same pauli pair
    function automatic t_row_word class_word(logic [3:0] pair, int count, int start,
                                             logic last);
        t_row_word w;
        int pos;
        w = '0;
        for (int i = 0; i < count; i++) begin
            pos = (start + i * 9) % 64;
            w.cx[pos] = pair[3];
            w.cz[pos] = pair[2];
            w.tx[pos] = pair[1];
            w.tz[pos] = pair[0];
        end
        w.last = last;
        return w;
    endfunction

    task automatic push_word(input t_row_word w);
        int gap;
        gap = pick_wait();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_ctrl_x_word <= w.cx;
        i_ctrl_z_word <= w.cz;
        i_targ_x_word <= w.tx;
        i_targ_z_word <= w.tz;
        i_last_word   <= w.last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_updates.push_back(rowsum_step(w));
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_val);
        $display("mismatch %s: got %h want %h", what, got, exp_val);
        error_count++;
    endtask

    // sink side: random stall after each accepted beat
    always @(posedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            i_stall <= (stall_hold > 1);
        end else if (o_valid && !i_stall) begin
            stall_draw = pick_wait();
            if (stall_draw > 0) begin
                i_stall <= 1'b1;
                stall_hold <= stall_draw;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_updates.size() == 0) begin
                report("unexpected beat", o_new_targ_x, '0);
            end else begin
                want = pending_updates.pop_front();
                if (o_new_targ_x !== want.nx) report("new_targ_x", o_new_targ_x, want.nx);
                if (o_new_targ_z !== want.nz) report("new_targ_z", o_new_targ_z, want.nz);
                if ($unsigned(o_phase_out) !== want.phase)
                    report("phase_out", 64'($unsigned(o_phase_out)), 64'(want.phase));
                if (o_phase_valid !== want.phase_valid)
                    report("phase_valid", 64'(o_phase_valid), 64'(want.phase_valid));
            end
        end
    end

    task automatic test_extremes();
        t_row_word w;
        steady = 1'b1;
        w = '0;
        push_word(w);
        w = '1;
        push_word(w);
        // 64 plus positions then 63 minus: phase comes out as +1
        push_word(class_word(PAIR_PLUS_A, 64, 0, 1'b0));
        push_word(class_word(PAIR_MINUS_C, 63, 5, 1'b1));
        push_word(class_word(PAIR_MINUS_A, 5, 63, 1'b1));
        steady = 1'b0;
    endtask

    // every pauli pair alone in a one-word row, at bits 3..63
    task automatic test_bit_classes();
        for (int k = 0; k < 16; k++) begin
            push_word(class_word(4'(k), 1, k * 4 + 3, 1'b1));
        end
    endtask

    // a multi-word row and a one-word row whose counts wrap the accumulator
    task automatic test_phase_wrap();
        push_word(class_word(PAIR_PLUS_A, 7, 1, 1'b0));
        push_word(class_word(PAIR_PLUS_A, 7, 2, 1'b0));
        push_word(class_word(PAIR_NONE, 0, 0, 1'b1));
        push_word(class_word(PAIR_PLUS_A, 63, 0, 1'b1));
    endtask

    task automatic test_random_rows();
        t_row_word w;
        int left;
        int row_len;
        left = RANDOM_WORDS;
        while (left > 0) begin
            row_len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
            steady = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < row_len; i++) begin
                case ($urandom_range(0, 3))
                    0: begin
                        w.cx = rand_word();
                        w.cz = rand_word();
                        w.tx = rand_word();
                        w.tz = rand_word();
                    end
                    1: begin
                        w.cx = rand_word() & rand_word() & rand_word();
                        w.cz = rand_word() & rand_word() & rand_word();
                        w.tx = rand_word() & rand_word() & rand_word();
                        w.tz = rand_word() & rand_word() & rand_word();
                    end
                    2: begin
                        w.cx = rand_word() | rand_word();
                        w.cz = rand_word() | rand_word();
                        w.tx = rand_word() | rand_word();
                        w.tz = rand_word() | rand_word();
                    end
                    default: begin
                        // target close to control
                        w.cx = rand_word();
                        w.cz = rand_word();
                        w.tx = w.cx ^ (rand_word() & rand_word() & rand_word());
                        w.tz = w.cz ^ (rand_word() & rand_word() & rand_word());
                    end
                endcase
                w.last = (i == row_len - 1) || ($urandom_range(0, 31) == 0);
                push_word(w);
            end
            left -= row_len;
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_bit_classes();
        test_phase_wrap();
        test_random_rows();
        i_valid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/srp_pkg.sv
hw/rtl/srp_lane.sv
hw/rtl/srp_merge.sv
hw/rtl/stabilizer_rowsum_phase.sv
hw/rtl/srp_checker.sv
bench/tb.sv
